>>> sv/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RSTMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rstmc: property violated");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RSTMC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rstmc: property violated");

`endif

>>> sv/rstmc_pkg.sv
// Shared types and constants of the maze carver.
package rstmc_pkg;

	localparam int MAX_GRID_DEF = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 5;
	localparam int RND_W        = 32;
	localparam int WALL_OUT_W   = 9;
	localparam int KIND_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GY   = 3'd4;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TREE = 2'd0,
		KIND_GOAL = 2'd1,
		KIND_NONE = 2'd2
	} step_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CARVE = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MARK_S,
		ST_MARK_G,
		ST_REF_RD,
		ST_REF_WR,
		ST_COUNT,
		ST_DIV,
		ST_GOAL,
		ST_FIND,
		ST_CUT,
		ST_BESIDE,
		ST_RESULT
	} seq_state_t;

endpackage

>>> sv/rstmc_cmd_if.sv
// Command channel: command and random word with valid/ready.
interface rstmc_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [rstmc_pkg::RND_W-1:0] random_value;

	modport source(output valid, output command, output random_value, input ready);
	modport sink(input valid, input command, input random_value, output ready);
endinterface

>>> sv/rstmc_res_if.sv
// Result channel: opened wall and step kind with valid/ready.
interface rstmc_res_if;
	logic                             valid;
	logic                             ready;
	logic [rstmc_pkg::WALL_OUT_W-1:0] opened_wall;
	logic [rstmc_pkg::KIND_W-1:0]     step_kind;

	modport source(output valid, output opened_wall, output step_kind, input ready);
	modport sink(input valid, input opened_wall, input step_kind, output ready);
endinterface

>>> sv/random_spanning_tree_maze_carver_top.sv
// Begin: a clearing sweep of both bitmaps, one entry a cycle.
// Step: 2*D*(D-1) frontier reads to count, a 32-bit restoring division, up to 2*D*(D-1) reads to find,
// then the update; both scans go through the single frontier read port.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset clears control and latched registers; bitmap RAM contents are cleared by every begin.
module random_spanning_tree_maze_carver_top #(
	parameter int MAX_GRID = rstmc_pkg::MAX_GRID_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rstmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rstmc_pkg::CFG_DATA_W-1:0] cfg_data,
	rstmc_cmd_if.sink                        cmd,
	rstmc_res_if.source                      res
);

	localparam int ROOM_CAP = MAX_GRID * MAX_GRID;
	localparam int WALL_CAP = 2 * MAX_GRID * (MAX_GRID - 1);
	localparam int SPAN     = (WALL_CAP > ROOM_CAP) ? WALL_CAP : ROOM_CAP;
	localparam int XW       = $clog2(MAX_GRID);
	localparam int DW       = $clog2(MAX_GRID + 1);
	localparam int RW       = $clog2(ROOM_CAP);
	localparam int WW       = $clog2(WALL_CAP);
	localparam int AW       = $clog2(SPAN + 1);
	localparam int CNW      = $clog2(WALL_CAP + 1);
	localparam int RND_W    = rstmc_pkg::RND_W;
	localparam int DCW      = $clog2(RND_W);
	localparam int OW       = rstmc_pkg::WALL_OUT_W;

	// configuration registers
	logic [4:0] reg_grid_q;
	logic [3:0] reg_sx_q, reg_sy_q, reg_gx_q, reg_gy_q;

	// latched maze geometry
	logic [DW-1:0]  dim_q;
	logic [XW-1:0]  sx_q, sy_q, gx_q, gy_q;
	logic [WW-1:0]  hcnt_q;
	logic [AW-1:0]  total_q;

	rstmc_pkg::seq_state_t state_q, state_n;
	rstmc_pkg::phase_t     phase_q;

	logic [XW-1:0]  rx_q, ry_q;
	logic [1:0]     nb_q;
	logic [AW-1:0]  addr_q;
	logic           rv_s1;
	logic [WW-1:0]  addr_s1;
	logic [CNW-1:0] cnt_q, seen_q, div_q;
	logic [CNW:0]   rem_q;
	logic [RND_W-1:0] dvd_q;
	logic [DCW-1:0] dcnt_q;
	logic           goal_mode_q;
	logic [XW-1:0]  scan_x_q, scan_y_q, scan_x_s1, scan_y_s1;
	logic           scan_v_q, scan_v_s1;
	logic [XW-1:0]  cut_x_q, cut_y_q;
	logic           cut_v_q;
	logic [WW-1:0]  cut_w_q;
	logic [OW-1:0]  res_wall_q, out_wall_q;
	rstmc_pkg::step_kind_t res_kind_q, out_kind_q;
	logic           out_valid_q;

	// memories
	logic           vis_we, fr_we;
	logic [RW-1:0]  vis_waddr, vis_raddr;
	logic [WW-1:0]  fr_waddr, fr_raddr;
	logic [0:0]     vis_wdata, fr_wdata, vis_rdata, fr_rdata;

	rstmc_ram #(.WIDTH(1), .DEPTH(ROOM_CAP)) u_visited (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rdata)
	);

	rstmc_ram #(.WIDTH(1), .DEPTH(WALL_CAP)) u_frontier (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	// geometry sampled at begin
	logic [31:0] grid_w, dim_n, sx_n, sy_n, gx_n, gy_n;
	assign grid_w = 32'(reg_grid_q);
	assign dim_n  = (grid_w < 32'd2) ? 32'd2 :
		((grid_w > 32'(MAX_GRID)) ? 32'(MAX_GRID) : grid_w);
	assign sx_n = (32'(reg_sx_q) >= dim_n) ? dim_n - 32'd1 : 32'(reg_sx_q);
	assign sy_n = (32'(reg_sy_q) >= dim_n) ? dim_n - 32'd1 : 32'(reg_sy_q);
	assign gx_n = (32'(reg_gx_q) >= dim_n) ? dim_n - 32'd1 : 32'(reg_gx_q);
	assign gy_n = (32'(reg_gy_q) >= dim_n) ? dim_n - 32'd1 : 32'(reg_gy_q);

	logic accept;
	assign accept = cmd.valid && cmd.ready;

	// refresh neighborhood of the current room
	logic [31:0] dim_w, dm1, ref_room, ref_hb, ref_vb, nb_room, nb_wall;
	logic        nb_en;
	assign dim_w    = 32'(dim_q);
	assign dm1      = dim_w - 32'd1;
	assign ref_room = 32'(rx_q) + dim_w * 32'(ry_q);
	assign ref_hb   = 32'(ry_q) * dm1 + 32'(rx_q);
	assign ref_vb   = 32'(hcnt_q) + ref_room;

	always_comb begin
		unique case (nb_q)
			2'd0: begin
				nb_en = (32'(rx_q) != 32'd0);
				nb_room = ref_room - 32'd1;
				nb_wall = ref_hb - 32'd1;
			end
			2'd1: begin
				nb_en = (32'(rx_q) != dm1);
				nb_room = ref_room + 32'd1;
				nb_wall = ref_hb;
			end
			2'd2: begin
				nb_en = (32'(ry_q) != 32'd0);
				nb_room = ref_room - dim_w;
				nb_wall = ref_vb - dim_w;
			end
			default: begin
				nb_en = (32'(ry_q) != dm1);
				nb_room = ref_room + dim_w;
				nb_wall = ref_vb;
			end
		endcase
	end

	// goal room candidates: left, right, top, bottom
	logic [31:0] g_room, g_hb, g_vb, g_sel;
	logic [31:0] c_wall [4];
	logic [3:0]  c_en;
	logic [CNW-1:0] g_n;
	assign g_room = 32'(gx_q) + dim_w * 32'(gy_q);
	assign g_hb   = 32'(gy_q) * dm1 + 32'(gx_q);
	assign g_vb   = 32'(hcnt_q) + g_room;
	assign c_wall[0] = g_hb - 32'd1;
	assign c_wall[1] = g_hb;
	assign c_wall[2] = g_vb - dim_w;
	assign c_wall[3] = g_vb;
	assign c_en[0] = (gx_q != '0) && !(gy_q == sy_q && 32'(gx_q) == 32'(sx_q) + 32'd1);
	assign c_en[1] = (32'(gx_q) != dm1) && !(gy_q == sy_q && 32'(sx_q) == 32'(gx_q) + 32'd1);
	assign c_en[2] = (gy_q != '0) && !(gx_q == sx_q && 32'(gy_q) == 32'(sy_q) + 32'd1);
	assign c_en[3] = (32'(gy_q) != dm1) && !(gx_q == sx_q && 32'(sy_q) == 32'(gy_q) + 32'd1);
	assign g_n = CNW'($countones(c_en));

	always_comb begin
		logic [2:0] idx;
		idx = 3'd0;
		g_sel = g_vb;
		for (int i = 0; i < 4; i++) begin
			if (c_en[i]) begin
				if (32'(idx) == 32'(rem_q)) begin
					g_sel = c_wall[i];
				end
				idx = idx + 3'd1;
			end
		end
	end

	// divider step: restoring remainder, one dividend bit a cycle
	logic [CNW:0] rem_sh, rem_n;
	assign rem_sh = {rem_q[CNW-1:0], dvd_q[RND_W-1]};
	assign rem_n  = (rem_sh >= {1'b0, div_q}) ? rem_sh - {1'b0, div_q} : rem_sh;

	// wall scan
	logic scan_busy, found;
	assign scan_busy = (state_q == rstmc_pkg::ST_COUNT || state_q == rstmc_pkg::ST_FIND)
		&& (addr_q < total_q);
	assign found = (state_q == rstmc_pkg::ST_FIND) && rv_s1 && fr_rdata[0]
		&& (seen_q == rem_q[CNW-1:0]);

	// rooms on either side of the cut wall
	logic [31:0] cut_a, cut_b;
	logic [XW-1:0] ch_x, ch_y;
	assign cut_a = 32'(cut_x_q) + dim_w * 32'(cut_y_q);
	assign cut_b = cut_v_q ? cut_a + dim_w : cut_a + 32'd1;
	assign ch_x  = (vis_rdata[0] && !cut_v_q) ? XW'(32'(cut_x_q) + 32'd1) : cut_x_q;
	assign ch_y  = (vis_rdata[0] && cut_v_q) ? XW'(32'(cut_y_q) + 32'd1) : cut_y_q;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rstmc_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.command == rstmc_pkg::CMD_BEGIN) begin
						state_n = rstmc_pkg::ST_CLEAR;
					end else if (phase_q == rstmc_pkg::PH_CARVE) begin
						state_n = rstmc_pkg::ST_COUNT;
					end else begin
						state_n = rstmc_pkg::ST_RESULT;
					end
				end
			end
			rstmc_pkg::ST_CLEAR: begin
				if (32'(addr_q) == 32'(SPAN - 1)) state_n = rstmc_pkg::ST_MARK_S;
			end
			rstmc_pkg::ST_MARK_S: state_n = rstmc_pkg::ST_MARK_G;
			rstmc_pkg::ST_MARK_G: state_n = rstmc_pkg::ST_REF_RD;
			rstmc_pkg::ST_REF_RD: begin
				if (nb_en) begin
					state_n = rstmc_pkg::ST_REF_WR;
				end else if (nb_q == 2'd3) begin
					state_n = rstmc_pkg::ST_RESULT;
				end
			end
			rstmc_pkg::ST_REF_WR: begin
				state_n = (nb_q == 2'd3) ? rstmc_pkg::ST_RESULT : rstmc_pkg::ST_REF_RD;
			end
			rstmc_pkg::ST_COUNT: begin
				if (!scan_busy && !rv_s1) state_n = rstmc_pkg::ST_DIV;
			end
			rstmc_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(RND_W - 1)) begin
					state_n = goal_mode_q ? rstmc_pkg::ST_GOAL : rstmc_pkg::ST_FIND;
				end
			end
			rstmc_pkg::ST_GOAL: state_n = rstmc_pkg::ST_RESULT;
			rstmc_pkg::ST_FIND: begin
				if (found) state_n = rstmc_pkg::ST_CUT;
			end
			rstmc_pkg::ST_CUT: state_n = rstmc_pkg::ST_BESIDE;
			rstmc_pkg::ST_BESIDE: state_n = rstmc_pkg::ST_REF_RD;
			rstmc_pkg::ST_RESULT: begin
				if (!out_valid_q || res.ready) state_n = rstmc_pkg::ST_IDLE;
			end
			default: state_n = rstmc_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = RW'(ref_room);
		vis_wdata = 1'b1;
		vis_raddr = RW'(nb_room);
		fr_we     = 1'b0;
		fr_waddr  = WW'(nb_wall);
		fr_wdata  = ~vis_rdata;
		fr_raddr  = addr_q[WW-1:0];
		cmd.ready = 1'b0;
		unique case (state_q)
			rstmc_pkg::ST_IDLE: cmd.ready = 1'b1;
			rstmc_pkg::ST_CLEAR: begin
				vis_we    = (32'(addr_q) < 32'(ROOM_CAP));
				vis_waddr = addr_q[RW-1:0];
				vis_wdata = 1'b0;
				fr_we     = (32'(addr_q) < 32'(WALL_CAP));
				fr_waddr  = addr_q[WW-1:0];
				fr_wdata  = 1'b0;
			end
			rstmc_pkg::ST_MARK_S: vis_we = 1'b1;
			rstmc_pkg::ST_MARK_G: begin
				vis_we    = 1'b1;
				vis_waddr = RW'(g_room);
			end
			rstmc_pkg::ST_REF_WR: fr_we = 1'b1;
			rstmc_pkg::ST_CUT: begin
				fr_we     = 1'b1;
				fr_waddr  = cut_w_q;
				fr_wdata  = 1'b0;
				vis_raddr = RW'(cut_a);
			end
			rstmc_pkg::ST_BESIDE: begin
				vis_we    = 1'b1;
				vis_waddr = vis_rdata[0] ? RW'(cut_b) : RW'(cut_a);
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_grid_q <= 5'd16;
			reg_sx_q   <= 4'd0;
			reg_sy_q   <= 4'd0;
			reg_gx_q   <= 4'd1;
			reg_gy_q   <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rstmc_pkg::CFG_GRID: reg_grid_q <= cfg_data;
				rstmc_pkg::CFG_SX:   reg_sx_q   <= cfg_data[3:0];
				rstmc_pkg::CFG_SY:   reg_sy_q   <= cfg_data[3:0];
				rstmc_pkg::CFG_GX:   reg_gx_q   <= cfg_data[3:0];
				rstmc_pkg::CFG_GY:   reg_gy_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rstmc_pkg::ST_IDLE;
			phase_q     <= rstmc_pkg::PH_IDLE;
			dim_q       <= DW'(MAX_GRID < 16 ? MAX_GRID : 16);
			sx_q        <= '0;
			sy_q        <= '0;
			gx_q        <= XW'(1);
			gy_q        <= XW'(1);
			hcnt_q      <= '0;
			total_q     <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			nb_q        <= '0;
			addr_q      <= '0;
			rv_s1       <= 1'b0;
			cnt_q       <= '0;
			seen_q      <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			goal_mode_q <= 1'b0;
			scan_x_q    <= '0;
			scan_y_q    <= '0;
			scan_v_q    <= 1'b0;
			res_kind_q  <= rstmc_pkg::KIND_NONE;
			out_valid_q <= 1'b0;
			out_kind_q  <= rstmc_pkg::KIND_NONE;
		end else begin
			state_q <= state_n;
			if (res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				rstmc_pkg::ST_IDLE: begin
					res_kind_q <= rstmc_pkg::KIND_NONE;
					res_wall_q <= '0;
					addr_q     <= '0;
					rv_s1      <= 1'b0;
					cnt_q      <= '0;
					dvd_q      <= cmd.random_value;
					if (accept && cmd.command == rstmc_pkg::CMD_BEGIN) begin
						dim_q   <= DW'(dim_n);
						sx_q    <= XW'(sx_n);
						sy_q    <= XW'(sy_n);
						gx_q    <= XW'(gx_n);
						gy_q    <= XW'(gy_n);
						rx_q    <= XW'(sx_n);
						ry_q    <= XW'(sy_n);
						hcnt_q  <= WW'(dim_n * (dim_n - 32'd1));
						total_q <= AW'(32'd2 * dim_n * (dim_n - 32'd1));
						phase_q <= rstmc_pkg::PH_CARVE;
					end
				end
				rstmc_pkg::ST_CLEAR: addr_q <= AW'(32'(addr_q) + 32'd1);
				rstmc_pkg::ST_MARK_G: nb_q <= 2'd0;
				rstmc_pkg::ST_REF_RD: begin
					if (!nb_en) nb_q <= nb_q + 2'd1;
				end
				rstmc_pkg::ST_REF_WR: nb_q <= nb_q + 2'd1;
				rstmc_pkg::ST_COUNT: begin
					rv_s1 <= scan_busy;
					if (scan_busy) addr_q <= AW'(32'(addr_q) + 32'd1);
					if (rv_s1 && fr_rdata[0]) cnt_q <= CNW'(32'(cnt_q) + 32'd1);
					if (!scan_busy && !rv_s1) begin
						goal_mode_q <= (cnt_q == '0);
						div_q       <= (cnt_q == '0) ? g_n : cnt_q;
						rem_q       <= '0;
						dcnt_q      <= '0;
					end
				end
				rstmc_pkg::ST_DIV: begin
					rem_q  <= rem_n;
					dvd_q  <= {dvd_q[RND_W-2:0], 1'b0};
					dcnt_q <= DCW'(32'(dcnt_q) + 32'd1);
					addr_q   <= '0;
					rv_s1    <= 1'b0;
					seen_q   <= '0;
					scan_x_q <= '0;
					scan_y_q <= '0;
					scan_v_q <= 1'b0;
				end
				rstmc_pkg::ST_GOAL: begin
					res_wall_q <= OW'(g_sel);
					res_kind_q <= rstmc_pkg::KIND_GOAL;
					phase_q    <= rstmc_pkg::PH_DONE;
				end
				rstmc_pkg::ST_FIND: begin
					rv_s1     <= scan_busy;
					addr_s1   <= addr_q[WW-1:0];
					scan_x_s1 <= scan_x_q;
					scan_y_s1 <= scan_y_q;
					scan_v_s1 <= scan_v_q;
					if (scan_busy) begin
						addr_q <= AW'(32'(addr_q) + 32'd1);
						// walk the wall's room coordinates alongside the index
						if (!scan_v_q) begin
							if (32'(scan_x_q) == dm1 - 32'd1) begin
								scan_x_q <= '0;
								if (32'(scan_y_q) == dm1) begin
									scan_y_q <= '0;
									scan_v_q <= 1'b1;
								end else begin
									scan_y_q <= XW'(32'(scan_y_q) + 32'd1);
								end
							end else begin
								scan_x_q <= XW'(32'(scan_x_q) + 32'd1);
							end
						end else if (32'(scan_x_q) == dm1) begin
							scan_x_q <= '0;
							scan_y_q <= XW'(32'(scan_y_q) + 32'd1);
						end else begin
							scan_x_q <= XW'(32'(scan_x_q) + 32'd1);
						end
					end
					if (found) begin
						cut_w_q    <= addr_s1;
						cut_x_q    <= scan_x_s1;
						cut_y_q    <= scan_y_s1;
						cut_v_q    <= scan_v_s1;
						res_wall_q <= OW'(addr_s1);
						res_kind_q <= rstmc_pkg::KIND_TREE;
					end else if (rv_s1 && fr_rdata[0]) begin
						seen_q <= CNW'(32'(seen_q) + 32'd1);
					end
				end
				rstmc_pkg::ST_BESIDE: begin
					rx_q <= ch_x;
					ry_q <= ch_y;
					nb_q <= 2'd0;
				end
				rstmc_pkg::ST_RESULT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= res_kind_q;
						out_wall_q  <= res_wall_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.opened_wall = out_wall_q;
	assign res.step_kind   = out_kind_q;

endmodule

>>> sv/rstmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rstmc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/rstmc_checker.sv
// Port-level checker for the maze carver, bound to the top level.
`include "assert_macros.svh"

module rstmc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [rstmc_pkg::WALL_OUT_W-1:0] out_wall,
	input logic [rstmc_pkg::KIND_W-1:0]     out_kind
);

	logic kind_ok;
	assign kind_ok = (out_kind == rstmc_pkg::KIND_TREE) || (out_kind == rstmc_pkg::KIND_GOAL)
		|| (out_kind == rstmc_pkg::KIND_NONE);

	`RSTMC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`RSTMC_ASSERT_IMP(a_kind_legal, out_valid, kind_ok)
	`RSTMC_ASSERT_IMP(a_none_zero, out_valid && out_kind == rstmc_pkg::KIND_NONE, out_wall == '0)
	`RSTMC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

bind random_spanning_tree_maze_carver_top rstmc_checker u_rstmc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(cmd.valid),
	.in_ready(cmd.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_wall(res.opened_wall),
	.out_kind(res.step_kind)
);

>>> verif/random_spanning_tree_maze_carver_checker.sv
// Checker for the maze carver: predicts every result and compares it with the block's output.
module random_spanning_tree_maze_carver_checker #(
	parameter int MAX_GRID = rstmc_pkg::MAX_GRID_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rstmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rstmc_pkg::CFG_DATA_W-1:0] cfg_data,
	rstmc_cmd_if                             cmd,
	rstmc_res_if                             res,
	output int                               fail_count,
	output int                               pending,
	output int                               tree_walls,
	output int                               goal_walls
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROOMS = MAX_GRID * MAX_GRID;
	localparam int WALLS = 2 * MAX_GRID * (MAX_GRID - 1);
	localparam int OW    = rstmc_pkg::WALL_OUT_W;
	localparam int RW    = rstmc_pkg::RND_W;

	typedef struct packed {
		logic [OW-1:0]         wall;
		rstmc_pkg::step_kind_t kind;
	} carve_result_t;

	carve_result_t expected_results[$];

	bit                visited[ROOMS];
	bit                frontier[WALLS];
	rstmc_pkg::phase_t phase;
	int unsigned       reg_grid, reg_sx, reg_sy, reg_gx, reg_gy;
	int unsigned       dim, sx, sy, gx, gy;

	function automatic int unsigned clamp_coord(int unsigned v);
		return (v >= dim) ? dim - 1 : v;
	endfunction

	// Rewrite the room's inner walls: frontier exactly where the neighbor is unvisited.
	function automatic void refresh_room(int unsigned room);
		int unsigned x, y, hb, vb;
		x = room % dim;
		y = room / dim;
		hb = y * (dim - 1) + x;
		vb = dim * (dim - 1) + room;
		if (x > 0) frontier[hb - 1] = !visited[room - 1];
		if (x < dim - 1) frontier[hb] = !visited[room + 1];
		if (y > 0) frontier[vb - dim] = !visited[room - dim];
		if (y < dim - 1) frontier[vb] = !visited[room + dim];
	endfunction

	function automatic int unsigned room_beside(int unsigned w);
		int unsigned hcount, a, b;
		hcount = dim * (dim - 1);
		if (w < hcount) begin
			a = (w % (dim - 1)) + dim * (w / (dim - 1));
			b = a + 1;
		end else begin
			a = w - hcount;
			b = a + dim;
		end
		return visited[a] ? b : a;
	endfunction

	// Candidates in order left, right, top, bottom; skip border walls and walls to the start.
	function automatic int unsigned goal_opening(logic [RW-1:0] rnd);
		int unsigned room, hb, vb, n;
		int unsigned cand[4];
		room = gx + dim * gy;
		hb = gy * (dim - 1) + gx;
		vb = dim * (dim - 1) + room;
		n = 0;
		if (!(gx == 0 || (gx - 1 == sx && gy == sy))) begin cand[n] = hb - 1; n++; end
		if (!(gx == dim - 1 || (gx + 1 == sx && gy == sy))) begin cand[n] = hb; n++; end
		if (!(gy == 0 || (gx == sx && gy - 1 == sy))) begin cand[n] = vb - dim; n++; end
		if (!(gy == dim - 1 || (gx == sx && gy + 1 == sy))) begin cand[n] = vb; n++; end
		if (n == 0) return vb;
		return cand[rnd % n];
	endfunction

	function automatic carve_result_t predict_carve(logic c, logic [RW-1:0] rnd);
		carve_result_t r;
		int unsigned total, count, pick, seen, w, room;
		r.wall = '0;
		r.kind = rstmc_pkg::KIND_NONE;
		if (c == rstmc_pkg::CMD_BEGIN) begin
			dim = (reg_grid < 2) ? 2 : ((reg_grid > MAX_GRID) ? MAX_GRID : reg_grid);
			sx = clamp_coord(reg_sx);
			sy = clamp_coord(reg_sy);
			gx = clamp_coord(reg_gx);
			gy = clamp_coord(reg_gy);
			foreach (visited[i]) visited[i] = 1'b0;
			foreach (frontier[i]) frontier[i] = 1'b0;
			visited[sx + dim * sy] = 1'b1;
			visited[gx + dim * gy] = 1'b1;
			refresh_room(sx + dim * sy);
			phase = rstmc_pkg::PH_CARVE;
		end else if (phase == rstmc_pkg::PH_CARVE) begin
			total = 2 * dim * (dim - 1);
			count = 0;
			for (int i = 0; i < total; i++) count += frontier[i];
			if (count == 0) begin
				r.wall = OW'(goal_opening(rnd));
				r.kind = rstmc_pkg::KIND_GOAL;
				phase = rstmc_pkg::PH_DONE;
			end else begin
				pick = rnd % count;
				seen = 0;
				w = 0;
				for (int i = 0; i < total; i++) begin
					if (frontier[i]) begin
						if (seen == pick) begin
							w = i;
							break;
						end
						seen++;
					end
				end
				frontier[w] = 1'b0;
				room = room_beside(w);
				visited[room] = 1'b1;
				refresh_room(room);
				r.wall = OW'(w);
				r.kind = rstmc_pkg::KIND_TREE;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		carve_result_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			foreach (visited[i]) visited[i] = 1'b0;
			foreach (frontier[i]) frontier[i] = 1'b0;
			phase = rstmc_pkg::PH_IDLE;
			reg_grid = 16; reg_sx = 0; reg_sy = 0; reg_gx = 1; reg_gy = 1;
			dim = (MAX_GRID < 16) ? MAX_GRID : 16;
			sx = 0; sy = 0; gx = 1; gy = 1;
			fail_count = 0;
			pending = 0;
			tree_walls = 0;
			goal_walls = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected: wall %0d kind %0d",
							$realtime, res.opened_wall, res.step_kind);
				end else begin
					exp_r = expected_results.pop_front();
					if (res.opened_wall !== exp_r.wall || res.step_kind !== exp_r.kind) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: expected wall %0d kind %0d, got wall %0d kind %0d",
								$realtime, exp_r.wall, exp_r.kind, res.opened_wall,
								res.step_kind);
					end
					if (exp_r.kind == rstmc_pkg::KIND_TREE) tree_walls++;
					if (exp_r.kind == rstmc_pkg::KIND_GOAL) goal_walls++;
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(predict_carve(cmd.command, cmd.random_value));
			if (cfg_we) begin
				case (cfg_index)
					rstmc_pkg::CFG_GRID: reg_grid = 32'(cfg_data);
					rstmc_pkg::CFG_SX:   reg_sx = 32'(cfg_data[3:0]);
					rstmc_pkg::CFG_SY:   reg_sy = 32'(cfg_data[3:0]);
					rstmc_pkg::CFG_GX:   reg_gx = 32'(cfg_data[3:0]);
					rstmc_pkg::CFG_GY:   reg_gy = 32'(cfg_data[3:0]);
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end
endmodule

>>> verif/random_spanning_tree_maze_carver_top_tb.sv
// Testbench top for the maze carver: clock, reset, command and config stimulus, verdict.
module random_spanning_tree_maze_carver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 580;
	localparam int LONG_HOLD   = 3000;
	localparam int IW          = rstmc_pkg::CFG_IDX_W;
	localparam int DATA_W      = rstmc_pkg::CFG_DATA_W;
	localparam int RW          = rstmc_pkg::RND_W;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IW-1:0]     cfg_index;
	logic [DATA_W-1:0] cfg_data;

	int fail_count, pending, tree_walls, goal_walls;
	int items_sent, results_taken, mazes_begun;
	bit no_gaps;

	rstmc_cmd_if cmd_ch();
	rstmc_res_if res_ch();

	random_spanning_tree_maze_carver_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch)
	);

	random_spanning_tree_maze_carver_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch), .fail_count(fail_count),
		.pending(pending), .tree_walls(tree_walls), .goal_walls(goal_walls)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#40_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [RW-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cmd(logic c, logic [RW-1:0] rnd);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.command = c;
		cmd_ch.random_value = rnd;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		if (c == rstmc_pkg::CMD_BEGIN) mazes_begun++;
	endtask

	// Drop valid and drain: config may only change with nothing in flight.
	task automatic wait_idle();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(logic [IW-1:0] idx, int unsigned value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = DATA_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(int unsigned g, int unsigned x0, int unsigned y0,
		int unsigned x1, int unsigned y1);
		wait_idle();
		cfg_write(rstmc_pkg::CFG_GRID, g);
		cfg_write(rstmc_pkg::CFG_SX, x0);
		cfg_write(rstmc_pkg::CFG_SY, y0);
		cfg_write(rstmc_pkg::CFG_GX, x1);
		cfg_write(rstmc_pkg::CFG_GY, y1);
	endtask

	// One maze: begin, then enough steps to finish plus one more, sometimes cut short.
	task automatic run_maze(int unsigned g, int unsigned x0, int unsigned y0,
		int unsigned x1, int unsigned y1);
		int unsigned d;
		int n;
		d = (g < 2) ? 2 : ((g > rstmc_pkg::MAX_GRID_DEF) ? rstmc_pkg::MAX_GRID_DEF : g);
		set_regs(g, x0, y0, x1, y1);
		no_gaps = ($urandom_range(0, 3) == 0);
		send_cmd(rstmc_pkg::CMD_BEGIN, pick_word());
		n = d * d;
		if ($urandom_range(0, 4) == 0) n = $urandom_range(1, d * d);
		repeat (n)
			send_cmd(($urandom_range(0, 29) == 0) ? rstmc_pkg::CMD_BEGIN : rstmc_pkg::CMD_STEP,
				pick_word());
	endtask

	// Result side: random stall per beat, one long hold-off to back up the block.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 6);
			if (results_taken == 40) stall = LONG_HOLD;
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			results_taken++;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = rstmc_pkg::CMD_BEGIN;
		cmd_ch.random_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// step while idle: no wall
		send_cmd(rstmc_pkg::CMD_STEP, '0);
		set_regs(2, 0, 0, 1, 1);
		send_cmd(rstmc_pkg::CMD_BEGIN, '1);
		send_cmd(rstmc_pkg::CMD_STEP, '0);
		send_cmd(rstmc_pkg::CMD_STEP, '1);
		send_cmd(rstmc_pkg::CMD_STEP, 32'h8000_0000);
		send_cmd(rstmc_pkg::CMD_STEP, 32'h5555_5555);
		// grid below two, coordinates clamped into the grid, start in the far corner
		set_regs(0, 15, 15, 15, 0);
		send_cmd(rstmc_pkg::CMD_BEGIN, '0);
		repeat (4) send_cmd(rstmc_pkg::CMD_STEP, pick_word());
		// oversized grid with goal on the start room
		set_regs(31, 5, 5, 5, 5);
		send_cmd(rstmc_pkg::CMD_BEGIN, 32'hAAAA_AAAA);
		repeat (3) send_cmd(rstmc_pkg::CMD_STEP, pick_word());
		// new grid size waits for the next begin
		wait_idle();
		cfg_write(rstmc_pkg::CFG_GRID, 3);
		repeat (2) send_cmd(rstmc_pkg::CMD_STEP, pick_word());
		send_cmd(rstmc_pkg::CMD_BEGIN, '0);
		repeat (9) send_cmd(rstmc_pkg::CMD_STEP, pick_word());

		run_maze(16, $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 15), $urandom_range(0, 15));
		while (items_sent < ITEM_TARGET)
			run_maze($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15));

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d commands over %0d mazes begun", items_sent, mazes_begun);
		$display("walls carved %0d, goal walls opened %0d", tree_walls, goal_walls);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> random_spanning_tree_maze_carver_top.f
+incdir+sv
sv/rstmc_pkg.sv
sv/rstmc_cmd_if.sv
sv/rstmc_res_if.sv
sv/rstmc_ram.sv
sv/random_spanning_tree_maze_carver_top.sv
sv/rstmc_checker.sv
verif/random_spanning_tree_maze_carver_checker.sv
verif/random_spanning_tree_maze_carver_top_tb.sv
